/* src/packed_multi_stack_store_top_macros.svh */
// Assertion macros for the packed multi-stack store
`ifndef PACKED_MULTI_STACK_STORE_TOP_MACROS_SVH
`define PACKED_MULTI_STACK_STORE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mss assertion failed");
`define MSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mss assertion failed");
`else
`define MSS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/mss_pkg.sv */
// Package: sizes, codes and shared types of the packed multi-stack store
`timescale 1ns / 1ps
package mss_pkg;

  localparam int CAPACITY   = 32;
  localparam int MAX_STACKS = 8;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_STACK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_TAKE_LOWER = 2'd2,
    CELL_TAKE_UPPER = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [IDX_W-1:0] pos;
  } shift_cmd_t;

endpackage

/* src/mss_if.sv */
// Channel interfaces: item input, result output and configuration write
`timescale 1ns / 1ps
interface mss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [2:0]         stack_number;
  logic signed [31:0] push_value;

  modport source (output valid, opcode, stack_number, push_value, input ready);
  modport sink   (input valid, opcode, stack_number, push_value, output ready);
endinterface

interface mss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [1:0]         status;
  logic [5:0]         fill_count;

  modport source (output valid, top_value, status, fill_count, input ready);
  modport sink   (input valid, top_value, status, fill_count, output ready);
endinterface

interface mss_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] stacks_in_use;

  modport source (output valid, stacks_in_use, input ready);
  modport sink   (input valid, stacks_in_use, output ready);
endinterface

/* src/mss_cell.sv */
// One storage cell of the shift chain
`timescale 1ns / 1ps
module mss_cell (
  input  logic                           clk,
  input  mss_pkg::cell_mode_t            mode,
  input  logic [mss_pkg::VALUE_BITS-1:0] load_data,
  input  logic [mss_pkg::VALUE_BITS-1:0] lower_data,
  input  logic [mss_pkg::VALUE_BITS-1:0] upper_data,
  output logic [mss_pkg::VALUE_BITS-1:0] data
);

  logic [mss_pkg::VALUE_BITS-1:0] data_r;
  logic [mss_pkg::VALUE_BITS-1:0] data_nxt;

  always_comb begin
    case (mode)
      mss_pkg::CELL_HOLD:       data_nxt = data_r;
      mss_pkg::CELL_LOAD:       data_nxt = load_data;
      mss_pkg::CELL_TAKE_LOWER: data_nxt = lower_data;
      mss_pkg::CELL_TAKE_UPPER: data_nxt = upper_data;
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

/* src/mss_chain.sv */
// Row of storage cells with insert/remove shift control and top read
`timescale 1ns / 1ps
module mss_chain (
  input  logic                           clk,
  input  mss_pkg::shift_cmd_t            cmd,
  input  logic [mss_pkg::VALUE_BITS-1:0] push_data,
  input  logic [mss_pkg::IDX_W-1:0]      read_pos,
  output logic [mss_pkg::VALUE_BITS-1:0] read_data
);

  logic [mss_pkg::VALUE_BITS-1:0] cell_q [mss_pkg::CAPACITY];
  mss_pkg::cell_mode_t            cell_mode [mss_pkg::CAPACITY];

  always_comb begin
    for (int i = 0; i < mss_pkg::CAPACITY; i++) begin
      cell_mode[i] = mss_pkg::CELL_HOLD;
      if (cmd.push) begin
        if (mss_pkg::IDX_W'(i) == cmd.pos) begin
          cell_mode[i] = mss_pkg::CELL_LOAD;
        end else if (mss_pkg::IDX_W'(i) > cmd.pos) begin
          cell_mode[i] = mss_pkg::CELL_TAKE_LOWER;
        end
      end else if (cmd.pop) begin
        if ((mss_pkg::IDX_W'(i) >= cmd.pos) && (i < mss_pkg::CAPACITY - 1)) begin
          cell_mode[i] = mss_pkg::CELL_TAKE_UPPER;
        end
      end
    end
  end

  always_comb begin
    read_data = '0;
    for (int i = 0; i < mss_pkg::CAPACITY; i++) begin
      if (mss_pkg::IDX_W'(i) == read_pos) begin
        read_data = cell_q[i];
      end
    end
  end

  for (genvar g = 0; g < mss_pkg::CAPACITY; g++) begin : g_cell
    logic [mss_pkg::VALUE_BITS-1:0] lower;
    logic [mss_pkg::VALUE_BITS-1:0] upper;

    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_q[g-1];
    end

    if (g == mss_pkg::CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_q[g+1];
    end

    mss_cell u_cell (
      .clk        (clk),
      .mode       (cell_mode[g]),
      .load_data  (push_data),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_q[g])
    );
  end

endmodule

/* src/packed_multi_stack_store_top.sv */
// Top level: stack boundaries, fill count, configuration and result register
// A result sits in the output register from the cycle after its input transfer.
// Throughput: one item per cycle; the cell row inserts or removes one element per cycle.
// A waiting result stalls new input only while out_ch.ready is low.
// Reset clears end marks, fill count and result valid, and sets the stack count to 1.
// Element cells are not reset and need no clearing pass.
`timescale 1ns / 1ps
`include "packed_multi_stack_store_top_macros.svh"
module packed_multi_stack_store_top (
  input  logic      clk,
  input  logic      rst_n,
  mss_in_if.sink    in_ch,
  mss_out_if.source out_ch,
  mss_cfg_if.sink   cfg_ch
);

  logic [mss_pkg::CNT_W-1:0] marks_r   [mss_pkg::MAX_STACKS];
  logic [mss_pkg::CNT_W-1:0] marks_nxt [mss_pkg::MAX_STACKS];
  logic [mss_pkg::CNT_W-1:0] fill_r;
  logic [mss_pkg::CNT_W-1:0] fill_nxt;
  logic [3:0]                stacks_r;
  logic                      out_valid_r;
  logic signed [31:0]        top_r;
  mss_pkg::status_t          status_r;
  logic [5:0]                fill_out_r;

  mss_pkg::opcode_t               op;
  mss_pkg::status_t               status_nxt;
  logic [mss_pkg::CNT_W-1:0]      mark_k;
  logic [mss_pkg::CNT_W-1:0]      start_k;
  logic                           accept;
  logic                           in_ready;
  logic                           stk_ok;
  logic                           full;
  logic                           empty;
  logic                           do_push;
  logic                           do_pop;
  logic                           read_ok;
  mss_pkg::shift_cmd_t            cmd;
  logic [mss_pkg::IDX_W-1:0]      read_pos;
  logic [mss_pkg::VALUE_BITS-1:0] read_data;
  logic [mss_pkg::VALUE_BITS-1:0] push_data;

  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  assign op = mss_pkg::opcode_t'(in_ch.opcode);

  always_comb begin
    mark_k  = '0;
    start_k = '0;
    for (int i = 0; i < mss_pkg::MAX_STACKS; i++) begin
      if (i == int'(in_ch.stack_number)) begin
        mark_k = marks_r[i];
      end
      if (i + 1 == int'(in_ch.stack_number)) begin
        start_k = marks_r[i];
      end
    end
  end

  assign stk_ok = (mss_pkg::CMP_W'(in_ch.stack_number) < mss_pkg::CMP_W'(stacks_r)) &&
                  (mss_pkg::CMP_W'(in_ch.stack_number) < mss_pkg::CMP_W'(mss_pkg::MAX_STACKS));
  assign full   = fill_r >= mss_pkg::CNT_W'(mss_pkg::CAPACITY);
  assign empty  = mark_k <= start_k;

  always_comb begin
    status_nxt = mss_pkg::ST_OK;
    if (op != mss_pkg::OP_NONE) begin
      if (!stk_ok) begin
        status_nxt = mss_pkg::ST_BAD_STACK;
      end else if (op == mss_pkg::OP_PUSH) begin
        if (full) begin
          status_nxt = mss_pkg::ST_FULL;
        end
      end else if (empty) begin
        status_nxt = mss_pkg::ST_EMPTY;
      end
    end
  end

  assign do_push = accept && (op == mss_pkg::OP_PUSH) && (status_nxt == mss_pkg::ST_OK);
  assign do_pop  = accept && (op == mss_pkg::OP_POP) && (status_nxt == mss_pkg::ST_OK);
  assign read_ok = ((op == mss_pkg::OP_POP) || (op == mss_pkg::OP_PEEK)) &&
                   (status_nxt == mss_pkg::ST_OK);

  assign read_pos  = mss_pkg::IDX_W'(mark_k - 1'b1);
  assign push_data = mss_pkg::VALUE_BITS'(in_ch.push_value);

  always_comb begin
    cmd.push = do_push;
    cmd.pop  = do_pop;
    cmd.pos  = do_push ? mark_k[mss_pkg::IDX_W-1:0] : read_pos;
  end

  mss_chain u_chain (
    .clk       (clk),
    .cmd       (cmd),
    .push_data (push_data),
    .read_pos  (read_pos),
    .read_data (read_data)
  );

  always_comb begin
    fill_nxt = fill_r;
    if (do_push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
    for (int i = 0; i < mss_pkg::MAX_STACKS; i++) begin
      marks_nxt[i] = marks_r[i];
      if (i >= int'(in_ch.stack_number)) begin
        if (do_push) begin
          marks_nxt[i] = marks_r[i] + 1'b1;
        end else if (do_pop) begin
          marks_nxt[i] = marks_r[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      stacks_r    <= 4'd1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mss_pkg::MAX_STACKS; i++) begin
        marks_r[i] <= '0;
      end
    end else begin
      fill_r <= fill_nxt;
      for (int i = 0; i < mss_pkg::MAX_STACKS; i++) begin
        marks_r[i] <= marks_nxt[i];
      end
      if (cfg_ch.valid) begin
        stacks_r <= cfg_ch.stacks_in_use;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r      <= read_ok ? 32'(read_data) : '0;
      status_r   <= status_nxt;
      fill_out_r <= 6'(fill_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.top_value  = top_r;
  assign out_ch.status     = status_r;
  assign out_ch.fill_count = fill_out_r;

  `MSS_ASSERT_SAME(a_fill_bound, clk, rst_n, 1'b1, fill_r <= mss_pkg::CNT_W'(mss_pkg::CAPACITY))
  `MSS_ASSERT_SAME(a_last_mark_is_fill, clk, rst_n, 1'b1, marks_r[mss_pkg::MAX_STACKS-1] == fill_r)
  `MSS_ASSERT_NEXT(a_push_grows, clk, rst_n, do_push, fill_r == mss_pkg::CNT_W'($past(fill_r) + 1'b1))
  `MSS_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_valid_r && (fill_out_r == 6'(fill_r)))

endmodule
